// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on a rising edge.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define RHSM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define RHSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/rhsm_pkg.sv
// ---------------------------------------------------------------------------
// Rolling hash matcher package
// Hash constants and the request/response types of the modular multiplier.
// ---------------------------------------------------------------------------
package rhsm_pkg;

  localparam int HASH_W = 30;
  localparam int MULT_W = 9;
  localparam int PROD_W = 39;
  localparam int QUOT_W = 10;
  localparam int MU_W   = 31;

  localparam logic [HASH_W-1:0] HASH_MOD  = 30'h3C069143;
  localparam logic [MULT_W-1:0] HASH_BASE = 9'd257;

  // Barrett factor floor(2^60 / modulus)
  localparam logic [MU_W-1:0] BARRETT_MU =
    31'(64'h1000_0000_0000_0000 / 64'h0000_0000_3C06_9143);

  // One (a * k + add) mod HASH_MOD request
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] a;
    logic [MULT_W-1:0] k;
    logic [7:0]        add;
  } mm_req_t;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] value;
  } mm_rsp_t;

endpackage

// File: hw/rtl/rhsm_modmul.sv
// ---------------------------------------------------------------------------
// Modular multiply-add unit
// Five-stage pipeline computing (a * k + add) mod HASH_MOD with a Barrett
// quotient estimate and two correction steps.
// ---------------------------------------------------------------------------
module rhsm_modmul
  import rhsm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  logic [4:0]        vld_r;
  logic [PROD_W-1:0] p1_r;
  logic [PROD_W-1:0] p2_r;
  logic [QUOT_W-1:0] q_r;
  logic [31:0]       r3_r;
  logic [31:0]       r4_r;
  logic [HASH_W-1:0] r5_r;

  logic [QUOT_W+MU_W-1:0] q_prod;
  logic [PROD_W-1:0]      qm;

  // Estimate the quotient from the top bits of the product
  assign q_prod = (QUOT_W+MU_W)'(p1_r[PROD_W-1:PROD_W-QUOT_W]) *
                  (QUOT_W+MU_W)'(BARRETT_MU);
  assign qm     = PROD_W'(q_r) * PROD_W'(HASH_MOD);

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], req.valid};
    end
  end

  // Multiply, estimate, subtract, correct twice
  always_ff @(posedge clk) begin
    p1_r <= PROD_W'(req.a) * PROD_W'(req.k) + PROD_W'(req.add);
    p2_r <= p1_r;
    q_r  <= q_prod[QUOT_W+MU_W-1:MU_W];
    r3_r <= 32'(p2_r - qm);
    r4_r <= (r3_r >= 32'(HASH_MOD)) ? r3_r - 32'(HASH_MOD) : r3_r;
    r5_r <= (r4_r >= 32'(HASH_MOD)) ? HASH_W'(r4_r - 32'(HASH_MOD)) : HASH_W'(r4_r);
  end

  assign rsp.valid = vld_r[4];
  assign rsp.value = r5_r;

endmodule

// File: hw/rtl/rolling_hash_substring_matcher_top.sv
// ---------------------------------------------------------------------------
// Rolling hash substring matcher
// Streaming base-257 rolling hash search with byte-wise match confirmation.
// ---------------------------------------------------------------------------
// Load a pattern with pattern beats (tuser = 0, tlast on its final byte),
// then stream text beats (tuser = 1, tlast on the final byte of a text).
// Each match gives one result beat with its start position; a text that
// ends before it holds as many bytes as the pattern gives an error beat
// (tuser = 1, position 0). Beats are handled one at a time. The cost per
// beat is set by the modular multiply pipeline, used serially: a pattern
// byte takes one pass for its hash, after one for the power once the
// power must also advance; a text byte takes one pass until the window
// is full and two after, and a hash hit adds a byte-wise compare through
// the pattern and window memories. A text beat that is not dropped also
// waits while the previous result beat is still held on the output.
// Pattern bytes beyond the store and dropped text beats never leave the
// idle state. Text beats before a full pattern has been loaded are dropped.
// Pattern and window storage need no clear after reset: only entries
// written since the last pattern start are read.
// ---------------------------------------------------------------------------
module rolling_hash_substring_matcher_top
  import rhsm_pkg::*;
#(
  parameter int MAX_PATTERN = 64,
  parameter int POS_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] func
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] position
  output logic        out_tuser   // [0] kind
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CW = (POS_BITS > LW) ? POS_BITS : LW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAT_POW,
    S_PAT_HASH,
    S_TXT_RD,
    S_TXT_DROP,
    S_TXT_SUB,
    S_TXT_HASH,
    S_TXT_EVAL,
    S_CMP_RD,
    S_CMP_CHK,
    S_FIN
  } state_t;

  state_t            state_r;
  logic [LW-1:0]     len_r;
  logic              done_r;
  logic [HASH_W-1:0] phash_r;
  logic [HASH_W-1:0] power_r;
  logic [HASH_W-1:0] thash_r;
  logic [AW-1:0]     slot_r;
  logic [POS_BITS-1:0] count_r;
  logic [7:0]        byte_r;
  logic              last_r;
  logic              sat_r;
  logic              match_r;
  logic [AW-1:0]     j_r;
  logic [AW-1:0]     widx_r;
  logic              out_valid_r;
  logic              out_kind_r;
  logic [31:0]       out_pos_r;

  logic [7:0] pmem [MAX_PATTERN];
  logic [7:0] wmem [MAX_PATTERN];
  logic [7:0] pmem_q;
  logic [7:0] wmem_q;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  logic              in_acc;
  logic [LW-1:0]     len_eff;
  logic [HASH_W-1:0] phash_eff;
  logic              pat_room;
  logic              txt_ok;
  logic              out_free;
  logic              out_load;
  logic              count_lt_m;
  logic [CW-1:0]     pos_diff;
  logic              pmem_we;
  logic              wmem_we;
  logic [AW-1:0]     wmem_raddr;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign len_eff    = done_r ? '0 : len_r;
  assign phash_eff  = done_r ? '0 : phash_r;
  assign pat_room   = (len_eff < LW'(MAX_PATTERN));
  assign txt_ok     = done_r && (len_r != '0);
  assign out_free   = !out_valid_r || out_tready;
  assign out_load   = (state_r == S_FIN) && out_free && (match_r || (last_r && count_lt_m));
  assign count_lt_m = (CW'(count_r) < CW'(len_r));
  assign pos_diff   = CW'(count_r) - CW'(len_r);

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_pos_r;

  // Issue multiplier requests
  always_comb begin
    mm_req       = '0;
    mm_req.a     = power_r;
    mm_req.k     = HASH_BASE;
    mm_req.add   = 8'd0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && !in_tuser && pat_room) begin
          mm_req.valid = 1'b1;
          if (len_eff == '0) begin
            mm_req.a   = phash_eff;
            mm_req.add = in_tdata;
          end
        end
      end
      S_PAT_POW: begin
        mm_req.valid = mm_rsp.valid;
        mm_req.a     = phash_r;
        mm_req.add   = byte_r;
      end
      S_TXT_RD: begin
        mm_req.valid = 1'b1;
        if (count_lt_m) begin
          mm_req.a   = thash_r;
          mm_req.add = byte_r;
        end else begin
          mm_req.k   = {1'b0, wmem_q};
        end
      end
      S_TXT_SUB: begin
        mm_req.valid = 1'b1;
        mm_req.a     = thash_r;
        mm_req.add   = byte_r;
      end
      default: begin
        mm_req.valid = 1'b0;
      end
    endcase
  end

  rhsm_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  // Memory controls
  assign pmem_we    = (state_r == S_IDLE) && in_acc && !in_tuser && pat_room;
  assign wmem_we    = (state_r == S_TXT_HASH) && mm_rsp.valid;
  assign wmem_raddr = (state_r == S_CMP_RD) ? widx_r : slot_r;

  // Pattern memory
  always_ff @(posedge clk) begin
    if (pmem_we) begin
      pmem[AW'(len_eff)] <= in_tdata;
    end
    pmem_q <= pmem[j_r];
  end

  // Window memory
  always_ff @(posedge clk) begin
    if (wmem_we) begin
      wmem[slot_r] <= byte_r;
    end
    wmem_q <= wmem[wmem_raddr];
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      done_r      <= 1'b1;
      phash_r     <= '0;
      power_r     <= HASH_W'(1);
      thash_r     <= '0;
      slot_r      <= '0;
      count_r     <= '0;
      sat_r       <= 1'b0;
      match_r     <= 1'b0;
      j_r         <= '0;
      widx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop a result once taken, unless a new one replaces it
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            byte_r <= in_tdata;
            last_r <= in_tlast;
            if (!in_tuser) begin
              // Start a new pattern and forget the text
              if (done_r) begin
                len_r   <= '0;
                phash_r <= '0;
                power_r <= HASH_W'(1);
                slot_r  <= '0;
                thash_r <= '0;
                count_r <= '0;
              end
              // Close the pattern on its last byte, keep it open otherwise
              done_r <= in_tlast;
              if (pat_room) begin
                state_r <= (len_eff != '0) ? S_PAT_POW : S_PAT_HASH;
              end
            end else if (txt_ok) begin
              state_r <= S_TXT_RD;
            end
          end
        end
        S_PAT_POW: begin
          if (mm_rsp.valid) begin
            power_r <= mm_rsp.value;
            state_r <= S_PAT_HASH;
          end
        end
        S_PAT_HASH: begin
          if (mm_rsp.valid) begin
            phash_r <= mm_rsp.value;
            len_r   <= len_r + LW'(1);
            state_r <= S_IDLE;
          end
        end
        S_TXT_RD: begin
          state_r <= count_lt_m ? S_TXT_HASH : S_TXT_DROP;
        end
        S_TXT_DROP: begin
          // Remove the oldest byte's weight from the hash
          if (mm_rsp.valid) begin
            if (thash_r >= mm_rsp.value) begin
              thash_r <= thash_r - mm_rsp.value;
            end else begin
              thash_r <= HASH_MOD - (mm_rsp.value - thash_r);
            end
            state_r <= S_TXT_SUB;
          end
        end
        S_TXT_SUB: begin
          state_r <= S_TXT_HASH;
        end
        S_TXT_HASH: begin
          if (mm_rsp.valid) begin
            thash_r <= mm_rsp.value;
            if ((LW'(slot_r) + LW'(1)) >= len_r) begin
              slot_r <= '0;
            end else begin
              slot_r <= slot_r + AW'(1);
            end
            sat_r <= &count_r;
            if (!(&count_r)) begin
              count_r <= count_r + POS_BITS'(1);
            end
            state_r <= S_TXT_EVAL;
          end
        end
        S_TXT_EVAL: begin
          match_r <= 1'b0;
          widx_r  <= slot_r;
          j_r     <= '0;
          if (!sat_r && !count_lt_m && (thash_r == phash_r)) begin
            state_r <= S_CMP_RD;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_CMP_RD: begin
          state_r <= S_CMP_CHK;
        end
        S_CMP_CHK: begin
          // Confirm the hit one byte at a time, oldest window byte first
          if (pmem_q != wmem_q) begin
            state_r <= S_FIN;
          end else if ((LW'(j_r) + LW'(1)) == len_r) begin
            match_r <= 1'b1;
            state_r <= S_FIN;
          end else begin
            j_r <= j_r + AW'(1);
            if ((LW'(widx_r) + LW'(1)) >= len_r) begin
              widx_r <= '0;
            end else begin
              widx_r <= widx_r + AW'(1);
            end
            state_r <= S_CMP_RD;
          end
        end
        S_FIN: begin
          // Hold until the output register is free
          if (out_free) begin
            if (match_r) begin
              out_valid_r <= 1'b1;
              out_kind_r  <= 1'b0;
              out_pos_r   <= 32'(pos_diff);
            end else if (last_r && count_lt_m) begin
              out_valid_r <= 1'b1;
              out_kind_r  <= 1'b1;
              out_pos_r   <= '0;
            end
            if (last_r) begin
              slot_r  <= '0;
              thash_r <= '0;
              count_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/rhsm_checker.sv
// ---------------------------------------------------------------------------
// Rolling hash matcher port checker
// Port-level assertions on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rhsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // Stalled result beat holds
  `RHSM_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result beat changed")

  // Short-text error carries position zero
  `RHSM_ASSERT(a_err_pos, clk, rst_n, out_tvalid && out_tuser |-> out_tdata == 32'd0, "error beat with nonzero position")

  // A new result is only produced while input is blocked
  `RHSM_ASSERT(a_res_busy, clk, rst_n, $rose(out_tvalid) |-> $past(!in_tready), "result appeared while idle")

  // Reset empties the output register
  `RHSM_ASSERT_ALWAYS(a_rst_out, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind rolling_hash_substring_matcher_top rhsm_checker u_rhsm_checker (.*);

// File: dv/rhsm_tb_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Rolling hash matcher verification package
// Beat codes and sizes that the stimulus and the checker share.
// ---------------------------------------------------------------------------
package rhsm_tb_pkg;

  // Input beat kinds, carried on in_tuser
  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_TEXT    = 1'b1;

  // Result beat kinds, carried on out_tuser
  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_SHORT = 1'b1;

  // Pattern bytes the block keeps
  localparam int MAX_PAT = 64;

endpackage

// File: dv/rhsm_match_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Rolling hash matcher checker
// Watches both streams, predicts match and short-text beats from accepted
// input beats, and compares each result beat against the oldest prediction.
// ---------------------------------------------------------------------------
module rhsm_match_checker
  import rhsm_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] func
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] position
  input  logic        out_tuser,  // [0] kind
  output int          fail_count,
  output int          pending
);

  localparam longint unsigned BASE      = 257;
  localparam longint unsigned MODULUS   = 64'h3C06_9143;
  localparam longint unsigned COUNT_SAT = 64'hFFFF_FFFF;
  localparam int              PRINT_CAP = 100;

  typedef struct packed {
    logic        kind;
    logic [31:0] position;
  } match_beat_t;

  match_beat_t expected_matches[$];

  // Pattern side
  logic [7:0]      pat_bytes [MAX_PAT];
  int unsigned     pat_len;
  longint unsigned pat_sig;
  longint unsigned lead_pow;   // BASE^(len-1) mod MODULUS
  bit              pat_closed;

  // Text side
  logic [7:0]      win_bytes [MAX_PAT];
  int unsigned     win_wr;
  longint unsigned txt_sig;
  longint unsigned txt_cnt;

  task automatic flag_mismatch(input string what);
    fail_count++;
    if (fail_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic void clear_text();
    foreach (win_bytes[i]) win_bytes[i] = 8'h00;
    win_wr  = 0;
    txt_sig = 0;
    txt_cnt = 0;
  endfunction

  function automatic void reset_search();
    foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
    pat_len    = 0;
    pat_sig    = 0;
    lead_pow   = 1;
    pat_closed = 1'b1;
    clear_text();
  endfunction

  // Compare the window, oldest byte first, against the stored pattern
  function automatic bit window_equals_pattern();
    int unsigned idx;
    idx = win_wr;
    for (int unsigned j = 0; j < pat_len; j++) begin
      if (idx >= pat_len) idx = 0;
      if (win_bytes[idx] != pat_bytes[j]) return 1'b0;
      idx++;
    end
    return 1'b1;
  endfunction

  function automatic void predict_search_beat(input logic func, input logic [7:0] b,
                                              input logic fin);
    longint unsigned m;
    longint unsigned prev_cnt;
    longint unsigned drop;
    bit              saturated;
    match_beat_t     beat;
    if (func == FUNC_PATTERN) begin
      // A pattern byte after a finished pattern starts over
      if (pat_closed) begin
        pat_len    = 0;
        pat_sig    = 0;
        lead_pow   = 1;
        pat_closed = 1'b0;
        clear_text();
      end
      // Drop bytes beyond the store, but honor their last flag
      if (pat_len < MAX_PAT) begin
        if (pat_len > 0) lead_pow = (lead_pow * BASE) % MODULUS;
        pat_bytes[pat_len] = b;
        pat_sig = (pat_sig * BASE + b) % MODULUS;
        pat_len++;
      end
      if (fin) pat_closed = 1'b1;
    end else if (pat_closed && pat_len != 0) begin
      m         = pat_len;
      prev_cnt  = txt_cnt;
      saturated = (prev_cnt >= COUNT_SAT);
      // Roll the hash: grow while filling, then drop the oldest byte
      if (prev_cnt < m) begin
        txt_sig = (txt_sig * BASE + b) % MODULUS;
      end else begin
        drop    = (longint'(win_bytes[win_wr]) * lead_pow) % MODULUS;
        txt_sig = ((txt_sig + MODULUS - drop) * BASE + b) % MODULUS;
      end
      win_bytes[win_wr] = b;
      win_wr++;
      if (win_wr >= pat_len) win_wr = 0;
      if (!saturated) txt_cnt = prev_cnt + 1;

      if (!saturated && txt_cnt >= m && txt_sig == pat_sig && window_equals_pattern()) begin
        beat.kind        = KIND_MATCH;
        beat.position    = 32'(txt_cnt - m);
        expected_matches = {expected_matches, beat};
      end
      // End of text: flag a text shorter than the pattern, then restart
      if (fin) begin
        if (txt_cnt < m) begin
          beat.kind        = KIND_SHORT;
          beat.position    = 32'd0;
          expected_matches = {expected_matches, beat};
        end
        clear_text();
      end
    end
  endfunction

  task automatic check_result_beat();
    match_beat_t want;
    if (expected_matches.size() == 0) begin
      flag_mismatch($sformatf("unexpected result beat kind=%0d position=%0d",
                              out_tuser, out_tdata));
    end else begin
      want = expected_matches.pop_front();
      if (out_tuser !== want.kind)
        flag_mismatch($sformatf("kind %0d, expected %0d", out_tuser, want.kind));
      if (out_tdata !== want.position)
        flag_mismatch($sformatf("position %0d, expected %0d", out_tdata, want.position));
    end
  endtask

  // Predict on accepted input beats, then compare accepted result beats
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_search();
      expected_matches.delete();
      pending = 0;
    end else begin
      if (in_tvalid && in_tready) predict_search_beat(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result_beat();
      pending = expected_matches.size();
    end
  end

endmodule

// File: dv/rolling_hash_substring_matcher_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Rolling hash matcher testbench
// Loads patterns and streams texts with planted copies of the pattern, with
// random gaps and stalls on both streams; the checker grades every result.
// ---------------------------------------------------------------------------
module rolling_hash_substring_matcher_top_tb;
  import rhsm_tb_pkg::*;

  localparam int RANDOM_ITEMS  = 650;
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 1_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // [0] func
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] position
  logic        out_tuser;  // [0] kind

  int fail_count;
  int pending;
  int cycle_cnt = 0;
  int work_items;
  int results_taken;
  bit idle_on;

  logic [7:0] pat_q[$];

  rolling_hash_substring_matcher_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  rhsm_match_checker match_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random ready gaps, plus two long hold-offs to back up the block
  initial begin
    int gap;
    out_tready    <= 1'b0;
    results_taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      results_taken++;
      if (results_taken == 30 || results_taken == 150) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
    end
  end

  // Offer one input beat after a random gap and hold it until accepted
  task automatic send_beat(input logic func, input logic [7:0] b, input logic fin);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= func;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending, wait for every predicted result, then let the block settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two-symbol alphabet makes matches common; the full range covers all bits
  function automatic logic [7:0] pick_byte(input bit narrow);
    if (narrow) return ($urandom_range(0, 1) != 0) ? 8'h5A : 8'hA5;
    return 8'($urandom_range(0, 255));
  endfunction

  // One pattern followed by a few texts with planted pattern copies
  task automatic run_session();
    int         m;
    int         eff;
    int         len;
    int         pick;
    int         n_txt;
    bit         narrow;
    bit         broken;
    logic [7:0] txt_q[$];

    // Mostly short patterns, some full-size, a few overlong
    pick = $urandom_range(0, 19);
    if (pick < 13)      m = $urandom_range(1, 6);
    else if (pick < 17) m = $urandom_range(7, 24);
    else if (pick < 19) m = MAX_PAT;
    else                m = $urandom_range(MAX_PAT + 1, MAX_PAT + 6);
    eff    = (m > MAX_PAT) ? MAX_PAT : m;
    narrow = ($urandom_range(0, 3) != 0);

    pat_q.delete();
    for (int i = 0; i < m; i++) pat_q = {pat_q, pick_byte(narrow)};

    // Load the pattern, now and then with a stray text beat in the middle
    for (int i = 0; i < m; i++) begin
      if (i > 0 && $urandom_range(0, 15) == 0)
        send_beat(FUNC_TEXT, pick_byte(1'b0), 1'($urandom_range(0, 1)));
      send_beat(FUNC_PATTERN, pat_q[i], i == m - 1);
      work_items++;
    end

    n_txt = $urandom_range(1, 3);
    for (int t = 0; t < n_txt; t++) begin
      // Occasionally a text shorter than the pattern
      if (eff > 1 && $urandom_range(0, 5) == 0) len = $urandom_range(1, eff - 1);
      else                                      len = eff + $urandom_range(0, 24);
      txt_q.delete();
      while (txt_q.size() < len) begin
        if ($urandom_range(0, 2) == 0) begin
          foreach (pat_q[i]) txt_q = {txt_q, pat_q[i]};
        end else begin
          txt_q = {txt_q, pick_byte(narrow)};
        end
      end
      // A broken text never sees its last flag; the next pattern cuts it off
      broken = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        send_beat(FUNC_TEXT, txt_q[i], !broken && i == len - 1);
        work_items++;
      end
      if (broken) break;
    end
  endtask

  // Stimulus and verdict
  initial begin
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'h00;
    in_tuser   <= FUNC_PATTERN;
    in_tlast   <= 1'b0;
    rst_n      <= 1'b0;
    work_items = 0;
    idle_on    = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Text before any pattern is dropped
    send_beat(FUNC_TEXT, 8'hFF, 1'b0);
    send_beat(FUNC_TEXT, 8'h00, 1'b1);

    // Two-byte pattern, with a text beat arriving while it loads
    send_beat(FUNC_PATTERN, 8'h41, 1'b0);
    send_beat(FUNC_TEXT, 8'h41, 1'b1);
    send_beat(FUNC_PATTERN, 8'h42, 1'b1);

    // Matches at 0 and 2, then a text shorter than the pattern
    send_beat(FUNC_TEXT, 8'h41, 1'b0);
    send_beat(FUNC_TEXT, 8'h42, 1'b0);
    send_beat(FUNC_TEXT, 8'h41, 1'b0);
    send_beat(FUNC_TEXT, 8'h42, 1'b1);
    send_beat(FUNC_TEXT, 8'h41, 1'b1);

    // Single-byte pattern at the top of the byte range
    send_beat(FUNC_PATTERN, 8'hFF, 1'b1);
    send_beat(FUNC_TEXT, 8'h00, 1'b0);
    send_beat(FUNC_TEXT, 8'hFF, 1'b0);
    send_beat(FUNC_TEXT, 8'hFF, 1'b1);

    // Extreme byte values in pattern and text
    send_beat(FUNC_PATTERN, 8'h00, 1'b0);
    send_beat(FUNC_PATTERN, 8'h80, 1'b0);
    send_beat(FUNC_PATTERN, 8'h7F, 1'b1);
    send_beat(FUNC_TEXT, 8'h00, 1'b0);
    send_beat(FUNC_TEXT, 8'h80, 1'b0);
    send_beat(FUNC_TEXT, 8'h7F, 1'b0);
    send_beat(FUNC_TEXT, 8'h80, 1'b1);
    drain_results();

    // Random sessions, with idle-free stretches and occasional full drains
    while (work_items < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      run_session();
      if ($urandom_range(0, 4) == 0) drain_results();
    end
    drain_results();

    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
